>>> src/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg: shared definitions for the accumulator CPU step block
// Opcode and status codes, counter width, default sizes and the ALU result
// record shared by the top level and the ALU.
// ----------------------------------------------------------------------------
package acs_pkg;

    // Program counter is one bit wider than a byte address so it can hold
    // the saturated end-of-memory value.
    localparam int PC_W = 9;

    localparam int ACS_MEM_DEPTH  = 256;
    localparam int ACS_START_ADDR = 80;

    // Item kinds on the input channel.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Instruction opcodes.
    localparam logic [7:0] OPC_HALT  = 8'h00;
    localparam logic [7:0] OPC_ADD   = 8'h40;
    localparam logic [7:0] OPC_SUB   = 8'h41;
    localparam logic [7:0] OPC_LOAD  = 8'h48;
    localparam logic [7:0] OPC_AND   = 8'h49;
    localparam logic [7:0] OPC_OR    = 8'h4A;
    localparam logic [7:0] OPC_XOR   = 8'h4B;
    localparam logic [7:0] OPC_NOT   = 8'h4C;
    localparam logic [7:0] OPC_SHL   = 8'h4D;
    localparam logic [7:0] OPC_SHR   = 8'h4E;
    localparam logic [7:0] OPC_INC   = 8'h4F;
    localparam logic [7:0] OPC_DEC   = 8'h50;
    localparam logic [7:0] OPC_DBL   = 8'h51;
    localparam logic [7:0] OPC_HALF  = 8'h52;
    localparam logic [7:0] OPC_ANDFF = 8'h53;
    localparam logic [7:0] OPC_ORFF  = 8'h54;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_HALT    = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_STOPPED = 2'd3
    } acs_status_t;

    typedef struct packed {
        logic [7:0]  acc;
        logic        use_operand;
        logic        stop;
        acs_status_t status;
    } acs_alu_res_t;

endpackage

>>> src/acs_ram.sv
// ----------------------------------------------------------------------------
// acs_ram: generic RAM, one write port and two registered read ports
// Reads return the contents from before a write to the same address in the
// same cycle.
// ----------------------------------------------------------------------------
module acs_ram #(
    parameter int   WIDTH = 8,
    parameter int   DEPTH = 256,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

>>> src/acs_alu.sv
// ----------------------------------------------------------------------------
// acs_alu: opcode decode and 8-bit accumulator operation
// Produces the new accumulator, whether an operand byte is consumed, and the
// stop and status outcome of one instruction.
// ----------------------------------------------------------------------------
module acs_alu (
    input  logic [7:0]           acc,
    input  logic [7:0]           opcode,
    input  logic [7:0]           operand,
    output acs_pkg::acs_alu_res_t res
);

    import acs_pkg::*;

    always_comb begin
        res.acc         = acc;
        res.use_operand = opcode inside {OPC_ADD, OPC_SUB, OPC_LOAD,
                                         OPC_AND, OPC_OR, OPC_XOR};
        res.stop        = 1'b0;
        res.status      = ST_OK;
        case (opcode)
            OPC_HALT: begin
                res.stop   = 1'b1;
                res.status = ST_HALT;
            end
            OPC_ADD:   res.acc = acc + operand;
            OPC_SUB:   res.acc = acc - operand;
            OPC_LOAD:  res.acc = operand;
            OPC_AND:   res.acc = acc & operand;
            OPC_OR:    res.acc = acc | operand;
            OPC_XOR:   res.acc = acc ^ operand;
            OPC_NOT:   res.acc = ~acc;
            OPC_SHL:   res.acc = {acc[6:0], 1'b0};
            OPC_SHR:   res.acc = {1'b0, acc[7:1]};
            OPC_INC:   res.acc = acc + 8'd1;
            OPC_DEC:   res.acc = acc - 8'd1;
            OPC_DBL:   res.acc = {acc[6:0], 1'b0};
            OPC_HALF:  res.acc = {1'b0, acc[7:1]};
            OPC_ANDFF: res.acc = acc;
            OPC_ORFF:  res.acc = 8'hFF;
            default: begin
                res.stop   = 1'b1;
                res.status = ST_UNKNOWN;
            end
        endcase
    end

endmodule

>>> src/accumulator_cpu_step.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_step: one-instruction-per-item 8-bit accumulator processor
// An accepted item is held in the input register, executes, and its result is
// held in the result register. Throughput: one item per cycle while m_ready does
// not stall the result register; memory reads are prefetched.
// Reset clears the accumulator, loads the counter with START_ADDR, leaves the
// machine running and clears one valid bit per memory byte (no clearing pass).
// ----------------------------------------------------------------------------
module accumulator_cpu_step #(
    parameter int MEM_DEPTH  = acs_pkg::ACS_MEM_DEPTH,
    parameter int START_ADDR = acs_pkg::ACS_START_ADDR
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_op,
    input  logic [7:0]               s_addr,
    input  logic [7:0]               s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [acs_pkg::PC_W-1:0] m_instr_addr,
    output logic [7:0]               m_acc_value,
    output logic [1:0]               m_status
);

    import acs_pkg::*;

    localparam int             AW       = $clog2(MEM_DEPTH);
    localparam logic [PC_W-1:0] DEPTH_PC = PC_W'(MEM_DEPTH);
    localparam logic [PC_W-1:0] START_PC = PC_W'(START_ADDR);

    // Input register: holds one accepted item until it executes.
    logic             in_valid_reg;
    logic             in_op_reg;
    logic [7:0]       in_addr_reg;
    logic [7:0]       in_data_reg;

    // Architectural state.
    logic [7:0]       acc_reg, acc_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic             stopped_reg, stopped_next;

    // Result register.
    logic             out_valid_reg;
    logic [PC_W-1:0]  out_instr_addr_reg;
    logic [7:0]       out_acc_reg;
    acs_status_t      out_status_reg;

    // Memory side. The RAM holds no reset state, so each byte carries a valid
    // bit; a byte that was never written since reset reads as zero. The RAM is
    // read at the counter value the state will hold in the next cycle, so the
    // opcode and operand bytes are already registered when the next item runs.
    // A write in the same cycle to a prefetched address is forwarded.
    logic [MEM_DEPTH-1:0] valid_bits_reg;
    logic             v0_reg, v0_next;
    logic             v1_reg, v1_next;
    logic             fwd0_reg, fwd0_next;
    logic             fwd1_reg, fwd1_next;
    logic [7:0]       fwd_data_reg;
    logic [7:0]       ram_q0, ram_q1;

    logic             exec_fire;
    logic             wr_en;
    logic [AW-1:0]    w_idx;
    logic             addr_in_range;
    logic [PC_W-1:0]  pc_plus1;
    logic [PC_W-1:0]  rd1_pc;
    logic [AW-1:0]    idx0, idx1;
    logic             ok0, ok1;
    logic [7:0]       byte0, byte1;
    acs_status_t      status_next;
    acs_alu_res_t     alu_res;

    // The execute stage fires whenever it holds an item and the result register
    // is free or being emptied, so with m_ready high a new item can enter every cycle.
    assign exec_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || exec_fire;

    // Opcode byte at the counter and operand byte just after it. The range
    // check is folded into the valid flags, so a byte past the end reads zero.
    assign byte0 = fwd0_reg ? fwd_data_reg : (v0_reg ? ram_q0 : 8'h00);
    assign byte1 = fwd1_reg ? fwd_data_reg : (v1_reg ? ram_q1 : 8'h00);

    assign pc_plus1      = pc_reg + PC_W'(1);
    assign addr_in_range = {1'b0, in_addr_reg} < DEPTH_PC;
    assign w_idx         = in_addr_reg[AW-1:0];

    acs_alu u_alu (
        .acc     (acc_reg),
        .opcode  (byte0),
        .operand (byte1),
        .res     (alu_res)
    );

    // Execute one item against the current state.
    always_comb begin
        acc_next     = acc_reg;
        pc_next      = pc_reg;
        stopped_next = stopped_reg;
        status_next  = ST_OK;
        wr_en        = 1'b0;
        if (exec_fire) begin
            if (in_op_reg == OP_WRITE) begin
                // Writes succeed even on a stopped machine; out of range is dropped.
                wr_en = addr_in_range;
            end else if (stopped_reg) begin
                status_next = ST_STOPPED;
            end else if (pc_reg >= DEPTH_PC) begin
                // Ran off the end of memory: stop without fetching.
                stopped_next = 1'b1;
                status_next  = ST_STOPPED;
            end else begin
                acc_next     = alu_res.acc;
                stopped_next = alu_res.stop;
                status_next  = alu_res.status;
                // The counter moves past the opcode, then past the operand
                // when one is used, saturating at the end of memory.
                if (alu_res.use_operand && (pc_plus1 < DEPTH_PC)) begin
                    pc_next = pc_plus1 + PC_W'(1);
                end else begin
                    pc_next = pc_plus1;
                end
            end
        end
    end

    // Prefetch addresses for the next cycle.
    always_comb begin
        rd1_pc    = pc_next + PC_W'(1);
        ok0       = pc_next < DEPTH_PC;
        ok1       = rd1_pc < DEPTH_PC;
        idx0      = pc_next[AW-1:0];
        idx1      = rd1_pc[AW-1:0];
        v0_next   = ok0 && valid_bits_reg[idx0];
        v1_next   = ok1 && valid_bits_reg[idx1];
        fwd0_next = wr_en && ok0 && (w_idx == idx0);
        fwd1_next = wr_en && ok1 && (w_idx == idx1);
    end

    acs_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (wr_en),
        .waddr   (w_idx),
        .wdata   (in_data_reg),
        .raddr_a (idx0),
        .raddr_b (idx1),
        .rdata_a (ram_q0),
        .rdata_b (ram_q1)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_op_reg   <= s_op;
            in_addr_reg <= s_addr;
            in_data_reg <= s_data;
        end
    end

    // Processor state, memory valid bits and prefetch flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg        <= 8'h00;
            pc_reg         <= START_PC;
            stopped_reg    <= 1'b0;
            valid_bits_reg <= '0;
            v0_reg         <= 1'b0;
            v1_reg         <= 1'b0;
            fwd0_reg       <= 1'b0;
            fwd1_reg       <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            pc_reg      <= pc_next;
            stopped_reg <= stopped_next;
            if (wr_en) begin
                valid_bits_reg[w_idx] <= 1'b1;
            end
            v0_reg   <= v0_next;
            v1_reg   <= v1_next;
            fwd0_reg <= fwd0_next;
            fwd1_reg <= fwd1_next;
        end
        fwd_data_reg <= in_data_reg;
    end

    // Result register: the instruction address is the counter before the item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (exec_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (exec_fire) begin
            out_instr_addr_reg <= pc_reg;
            out_acc_reg        <= acc_next;
            out_status_reg     <= status_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_instr_addr = out_instr_addr_reg;
    assign m_acc_value  = out_acc_reg;
    assign m_status     = 2'(out_status_reg);

`ifndef NO_ASSERTIONS
    // The counter saturates at the end of memory.
    a_pc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= DEPTH_PC)
        else $error("program counter beyond end of memory");

    // A stopped machine stays stopped until reset.
    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("stopped machine restarted");

    // A halt or unknown opcode result always leaves the machine stopped.
    a_stop_on_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && (status_next == ST_HALT || status_next == ST_UNKNOWN)
        |=> stopped_reg)
        else $error("halt or unknown opcode did not stop the machine");

    // A held result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !exec_fire)
        else $error("result register overwritten while stalled");
`endif

endmodule
